// ----- design/e2hp_pkg.sv -----
`timescale 1ns / 1ps

package e2hp_pkg;

  // Exponent word: signed Q1.62.
  localparam int unsigned X_W    = 64;
  localparam int unsigned X_FRAC = 62;

  // Result word: unsigned Q1.62.
  localparam int unsigned OUT_W = 63;

  // Multiplier slicing: 32-bit limbs, the exponent splits into two of them.
  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned X_LIMBS = X_W / LIMB_W;

  // Integer bits of the accumulator, sign included. Every Horner partial sum
  // stays inside (-8, 8) for any exponent in [-2, 2).
  localparam int unsigned ACC_INT_BITS = 4;

  // Widest accumulator the coefficient function has to produce.
  localparam int unsigned MAX_FRAC_BITS = 160;
  localparam int unsigned MAX_ACC_W     = MAX_FRAC_BITS + ACC_INT_BITS;

  // Scratch width for the coefficient scaling.
  localparam int unsigned COEF_CALC_W = 256;

  // Rounded accumulator after dropping the extra fractional bits.
  localparam int unsigned Q_W = ACC_INT_BITS + X_FRAC;

  // Taylor coefficients ln(2)^k / k!, each one mantissa / 2^shift.
  localparam int unsigned TAB_LEN = 21;

  localparam logic [63:0] COEF_MANT [TAB_LEN] = '{
    64'h8000000000000000, 64'hb17217f7d1cf79ac, 64'hf5fdeffc162c7543,
    64'he35846b82505fc5a, 64'h9d955b7dd273b94e, 64'haec3ff3c53398884,
    64'ha184897c363c3b7a, 64'hffe5fe2c45863436, 64'hb160111d2e411fec,
    64'hda929e9caf3e1ed2, 64'hf267a8ac5c764fb8, 64'hf465639a8dd92608,
    64'he1deb287e14c2f16, 64'hc0b0c98b3687cb14, 64'h98a4b26ac3c54ba0,
    64'he1b7421d82010f34, 64'h9c744d73cfc59c92, 64'hcc2225a0e12d3eab,
    64'hfb8bb5eda1b4aeba, 64'h92d3f65c1ae326d7, 64'ha2d6625a8289ac27
  };

  localparam logic [7:0] COEF_SHIFT [TAB_LEN] = '{
    8'd63,  8'd64,  8'd66,  8'd68,  8'd70,  8'd73,  8'd76,
    8'd80,  8'd83,  8'd87,  8'd91,  8'd95,  8'd99,  8'd103,
    8'd107, 8'd112, 8'd116, 8'd121, 8'd126, 8'd130, 8'd135
  };

  // Coefficient idx with frac_bits fractional bits, rounded to nearest with
  // ties up. Coefficients past the end of the table are zero.
  function automatic logic [MAX_ACC_W-1:0] coef_fixed(int unsigned idx,
                                                      int unsigned frac_bits);
    logic [COEF_CALC_W-1:0] v;
    logic [4:0]             ti;
    int                     e;
    v  = '0;
    ti = idx[4:0];
    e  = 0;
    if (idx < TAB_LEN) begin
      v = COEF_CALC_W'(COEF_MANT[ti]);
      e = int'(frac_bits) - int'(COEF_SHIFT[ti]) + 1;
      if (e >= 0) begin
        v = v << e;
      end else begin
        v = v >> (-e);
      end
      v = v + COEF_CALC_W'(1);
      v = v >> 1;
    end
    return v[MAX_ACC_W-1:0];
  endfunction

endpackage

// ----- design/exp2_horner_polynomial_core.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+---------------------------
// input   | in        | in_valid_i / in_stall_o   | x_value_i, signed Q1.62
// output  | out       | out_valid_o / out_stall_i | power_value_o, Q1.62
//
// One word enters per cycle while in_stall_o is low. Each Horner step is a
// three-stage slice of limb multipliers, product summation and coefficient
// add; rounding and the output register follow the chain. Reset clears only
// the valid bits. in_stall_o is high while the skid slot holds a word; the
// whole pipeline then holds still.
module exp2_horner_polynomial_core #(
  parameter int unsigned NUM_COEFFS    = 21,
  parameter int unsigned ACC_FRAC_BITS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [e2hp_pkg::X_W-1:0]   x_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [e2hp_pkg::OUT_W-1:0]        power_value_o
);

  localparam int unsigned ACC_W = ACC_FRAC_BITS + e2hp_pkg::ACC_INT_BITS;
  localparam int unsigned NSTEP = NUM_COEFFS - 1;

  // The top coefficient seeds the accumulator.
  localparam logic [e2hp_pkg::MAX_ACC_W-1:0] COEF_TOP_FULL =
    e2hp_pkg::coef_fixed(NUM_COEFFS - 1, ACC_FRAC_BITS);
  localparam logic [ACC_W-1:0] COEF_TOP = COEF_TOP_FULL[ACC_W-1:0];

  logic                            en;
  logic                            skid_full;
  logic                            chain_valid [NSTEP+1];
  logic signed [e2hp_pkg::X_W-1:0] chain_x     [NSTEP+1];
  logic signed [ACC_W-1:0]         chain_r     [NSTEP+1];
  logic                            rnd_valid;
  logic [e2hp_pkg::OUT_W-1:0]      rnd_power;

  // The pipeline advances whenever the skid slot is free.
  assign en         = !skid_full;
  assign in_stall_o = skid_full;

  assign chain_valid[0] = in_valid_i;
  assign chain_x[0]     = x_value_i;
  assign chain_r[0]     = COEF_TOP;

  // Horner chain, top coefficient down to the constant term.
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    e2hp_horner_step #(
      .ACC_FRAC_BITS(ACC_FRAC_BITS),
      .COEF_IDX     (NUM_COEFFS - 2 - s)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(chain_valid[s]),
      .x_i    (chain_x[s]),
      .r_i    (chain_r[s]),
      .valid_o(chain_valid[s+1]),
      .x_o    (chain_x[s+1]),
      .r_o    (chain_r[s+1])
    );
  end

  e2hp_round #(
    .ACC_FRAC_BITS(ACC_FRAC_BITS)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(chain_valid[NSTEP]),
    .r_i    (chain_r[NSTEP]),
    .valid_o(rnd_valid),
    .power_o(rnd_power)
  );

  e2hp_skid u_skid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(rnd_valid),
    .s_data_i (rnd_power),
    .s_full_o (skid_full),
    .m_valid_o(out_valid_o),
    .m_data_o (power_value_o),
    .m_stall_i(out_stall_i)
  );

endmodule

// ----- design/e2hp_horner_step.sv -----
`timescale 1ns / 1ps

// One Horner step r_out = floor(r_in * x / 2^62) + c, in three stages:
// limb products, product summation with truncation, coefficient add.
module e2hp_horner_step #(
  parameter int unsigned ACC_FRAC_BITS = 128,
  parameter int unsigned COEF_IDX      = 0
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  en_i,
  input  logic                                                  valid_i,
  input  logic signed [e2hp_pkg::X_W-1:0]                       x_i,
  input  logic signed [ACC_FRAC_BITS+e2hp_pkg::ACC_INT_BITS-1:0] r_i,
  output logic                                                  valid_o,
  output logic signed [e2hp_pkg::X_W-1:0]                       x_o,
  output logic signed [ACC_FRAC_BITS+e2hp_pkg::ACC_INT_BITS-1:0] r_o
);

  localparam int unsigned ACC_W   = ACC_FRAC_BITS + e2hp_pkg::ACC_INT_BITS;
  localparam int unsigned LIMB_W  = e2hp_pkg::LIMB_W;
  localparam int unsigned X_LIMBS = e2hp_pkg::X_LIMBS;
  localparam int unsigned NLIMB   = (ACC_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned EXT_W   = NLIMB * LIMB_W;
  localparam int unsigned PP_W    = 2 * (LIMB_W + 1);
  localparam int unsigned SUM_W   = ACC_W + e2hp_pkg::X_FRAC;

  localparam logic [e2hp_pkg::MAX_ACC_W-1:0] COEF_FULL =
    e2hp_pkg::coef_fixed(COEF_IDX, ACC_FRAC_BITS);
  localparam logic [ACC_W-1:0] COEF = COEF_FULL[ACC_W-1:0];

  // Stage A: 33x33 signed limb products. Lower limbs are zero-extended and
  // the top limb of each operand carries the sign.
  logic [EXT_W-1:0]         r_ext;
  logic signed [LIMB_W:0]   a_limb [NLIMB];
  logic signed [LIMB_W:0]   b_limb [X_LIMBS];
  logic signed [PP_W-1:0]   pp_d   [NLIMB][X_LIMBS];
  logic signed [PP_W-1:0]   pp_q   [NLIMB][X_LIMBS];
  logic signed [e2hp_pkg::X_W-1:0] x_a_q;
  logic                     valid_a_q;

  assign r_ext = EXT_W'(r_i);

  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      if (i == NLIMB - 1) begin
        a_limb[i] = {r_ext[EXT_W-1], r_ext[LIMB_W*i +: LIMB_W]};
      end else begin
        a_limb[i] = {1'b0, r_ext[LIMB_W*i +: LIMB_W]};
      end
    end
    for (int j = 0; j < X_LIMBS; j++) begin
      if (j == X_LIMBS - 1) begin
        b_limb[j] = {x_i[e2hp_pkg::X_W-1], x_i[LIMB_W*j +: LIMB_W]};
      end else begin
        b_limb[j] = {1'b0, x_i[LIMB_W*j +: LIMB_W]};
      end
    end
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < X_LIMBS; j++) begin
        pp_d[i][j] = a_limb[i] * b_limb[j];
      end
    end
  end

  // Stage B: sum the shifted limb products modulo 2^SUM_W and keep the bits
  // above the exponent's fraction, which floors the product.
  logic [SUM_W-1:0]         sum_w;
  logic [ACC_W-1:0]         prod_q;
  logic signed [e2hp_pkg::X_W-1:0] x_b_q;
  logic                     valid_b_q;

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < X_LIMBS; j++) begin
        sum_w = sum_w + (SUM_W'(pp_q[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  // Stage C: add the coefficient of this step.
  logic [ACC_W-1:0]         r_d;
  logic [ACC_W-1:0]         r_q;
  logic signed [e2hp_pkg::X_W-1:0] x_c_q;
  logic                     valid_c_q;

  assign r_d = prod_q + COEF;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q   <= pp_d;
      x_a_q  <= x_i;
      prod_q <= sum_w[SUM_W-1 -: ACC_W];
      x_b_q  <= x_a_q;
      r_q    <= r_d;
      x_c_q  <= x_b_q;
    end
  end

  assign valid_o = valid_c_q;
  assign x_o     = x_c_q;
  assign r_o     = r_q;

endmodule

// ----- design/e2hp_round.sv -----
`timescale 1ns / 1ps

// Rounds the accumulator to Q1.62 (nearest, ties up) and saturates.
module e2hp_round #(
  parameter int unsigned ACC_FRAC_BITS = 128
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  en_i,
  input  logic                                                  valid_i,
  input  logic signed [ACC_FRAC_BITS+e2hp_pkg::ACC_INT_BITS-1:0] r_i,
  output logic                                                  valid_o,
  output logic [e2hp_pkg::OUT_W-1:0]                            power_o
);

  localparam int unsigned ACC_W = ACC_FRAC_BITS + e2hp_pkg::ACC_INT_BITS;
  localparam int unsigned Q_W   = e2hp_pkg::Q_W;
  localparam int unsigned OUT_W = e2hp_pkg::OUT_W;
  localparam logic [ACC_W-1:0] HALF =
    ACC_W'(1) << (ACC_FRAC_BITS - e2hp_pkg::X_FRAC - 1);

  logic [ACC_W-1:0] rnd;
  logic [Q_W-1:0]   q;
  logic [OUT_W-1:0] power_d;
  logic [OUT_W-1:0] power_q;
  logic             valid_q;

  // Add half an output step, drop the extra fraction, then clamp.
  always_comb begin
    rnd = r_i + HALF;
    q   = rnd[ACC_W-1 -: Q_W];
    if (q[Q_W-1]) begin
      power_d = '0;
    end else if (|q[Q_W-2:OUT_W]) begin
      power_d = '1;
    end else begin
      power_d = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      power_q <= power_d;
    end
  end

  assign valid_o = valid_q;
  assign power_o = power_q;

endmodule

// ----- design/e2hp_skid.sv -----
`timescale 1ns / 1ps

// Output register with a one-word skid slot. The pipeline moves whenever
// the skid slot is empty, so the stall toward it is a plain flop.
module e2hp_skid (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  input  logic [e2hp_pkg::OUT_W-1:0] s_data_i,
  output logic                       s_full_o,
  output logic                       m_valid_o,
  output logic [e2hp_pkg::OUT_W-1:0] m_data_o,
  input  logic                       m_stall_i
);

  logic                       out_valid_d, out_valid_q;
  logic [e2hp_pkg::OUT_W-1:0] out_d, out_q;
  logic                       skid_valid_d, skid_valid_q;
  logic [e2hp_pkg::OUT_W-1:0] skid_d, skid_q;
  logic                       out_free;

  // The output register frees up when empty or when its word is taken.
  always_comb begin
    out_free     = !out_valid_q || !m_stall_i;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = s_data_i;
        out_valid_d = s_valid_i;
      end
    end else if (s_valid_i && !skid_valid_q) begin
      skid_d       = s_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_full_o  = skid_valid_q;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

endmodule

// ----- design/e2hp_checker.sv -----
`timescale 1ns / 1ps

module e2hp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [e2hp_pkg::X_W-1:0]     x_value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [e2hp_pkg::OUT_W-1:0]   power_value_o
);

  // A stalled exponent word holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(x_value_i))
    else $error("exponent word changed while stalled");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_value_o))
    else $error("result word changed while stalled");

  // Input backpressure only happens behind a waiting result.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // The skid slot only fills after the output side stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_stall_i))
    else $error("input stalled without an output stall");

  // Backpressure persists as long as the output stays stalled.
  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i |=> in_stall_o)
    else $error("input stall released while output still stalled");

endmodule

bind exp2_horner_polynomial_core e2hp_checker u_e2hp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .x_value_i    (x_value_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .power_value_o(power_value_o)
);

// ----- test/tb_exp2_horner_polynomial_core.sv -----
`timescale 1ns / 1ps

module tb_exp2_horner_polynomial_core;

  localparam int unsigned HORNER_TERMS   = 21;
  localparam int unsigned FRAC_BITS      = 128;
  localparam int unsigned PIPE_LATENCY   = 3 * (HORNER_TERMS - 1) + 2;
  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_TRIGGER   = 120;

  typedef logic signed [255:0] wide_t;

  // One exponent word, the idle cycles that follow it, and whether the
  // sender waits for the pipeline to drain before offering it.
  typedef struct {
    logic signed [e2hp_pkg::X_W-1:0] x;
    int unsigned                     gap;
    bit                              drain;
  } exponent_item_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [e2hp_pkg::X_W-1:0] x_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [e2hp_pkg::OUT_W-1:0]      power_value;

  exponent_item_t             exponent_queue [$];
  logic [e2hp_pkg::OUT_W-1:0] pending_powers [$];
  int unsigned                error_count = 0;
  int unsigned                results_seen = 0;

  exp2_horner_polynomial_core #(
    .NUM_COEFFS   (HORNER_TERMS),
    .ACC_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .x_value_i    (x_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .power_value_o(power_value)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Taylor coefficient k scaled to FRAC_BITS fractional bits, round half up.
  function automatic wide_t taylor_coef(int k);
    logic [255:0] v;
    int           e;
    v = '0;
    if (k >= 0 && k < int'(e2hp_pkg::TAB_LEN)) begin
      v = 256'(e2hp_pkg::COEF_MANT[k]);
      e = int'(FRAC_BITS) - int'(e2hp_pkg::COEF_SHIFT[k]) + 1;
      if (e >= 0) begin
        v = v << e;
      end else begin
        v = v >> (-e);
      end
      v = (v + 256'(1)) >> 1;
    end
    return v;
  endfunction

  // Horner evaluation of 2^x with truncated products, then rounding to Q1.62
  // with saturation at the top and a floor of zero.
  function automatic logic [e2hp_pkg::OUT_W-1:0] power_of_two(
      logic signed [e2hp_pkg::X_W-1:0] x);
    wide_t acc;
    wide_t xw;
    int    k;
    xw  = x;
    acc = taylor_coef(HORNER_TERMS - 1);
    for (k = HORNER_TERMS - 2; k >= 0; k--) begin
      acc = (acc * xw) >>> e2hp_pkg::X_FRAC;
      acc = acc + taylor_coef(k);
    end
    acc = acc + (256'(1) << (FRAC_BITS - 63));
    acc = acc >>> (FRAC_BITS - e2hp_pkg::X_FRAC);
    if (acc[255]) begin
      return '0;
    end else if (acc[255:e2hp_pkg::OUT_W] != '0) begin
      return '1;
    end
    return acc[e2hp_pkg::OUT_W-1:0];
  endfunction

  // Mostly exponents inside [-1, 1], some near zero or near the ends, and a
  // few raw patterns that cover the whole Q1.62 word.
  function automatic logic signed [e2hp_pkg::X_W-1:0] random_exponent();
    logic signed [e2hp_pkg::X_W-1:0] raw;
    int unsigned                     sel;
    raw = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      return raw >>> 1;
    end else if (sel < 82) begin
      return raw >>> $urandom_range(2, 62);
    end else if (sel < 94) begin
      if (raw[0]) begin
        return (64'sd1 <<< e2hp_pkg::X_FRAC) - $urandom_range(0, 1000);
      end
      return -(64'sd1 <<< e2hp_pkg::X_FRAC) + $urandom_range(0, 1000);
    end
    return raw;
  endfunction

  task automatic report_mismatch(string what, logic [e2hp_pkg::OUT_W-1:0] want,
                                 logic [e2hp_pkg::OUT_W-1:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  // Sender: offers the queued words, predicts each accepted one, and idles
  // or waits for a drained pipeline as each item asks.
  always @(posedge clk_i) begin : drive_proc
    logic                            offer;
    logic signed [e2hp_pkg::X_W-1:0] next_x;
    exponent_item_t                  item;
    int unsigned                     gap_left;
    int unsigned                     cur_gap;
    offer  = in_valid;
    next_x = x_value;
    if (in_valid && !in_stall) begin
      pending_powers.push_back(power_of_two(x_value));
      offer    = 1'b0;
      gap_left = cur_gap;
    end
    if (rst_ni && !offer) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (exponent_queue.size() > 0) begin
        if (!exponent_queue[0].drain || pending_powers.size() == 0) begin
          item    = exponent_queue.pop_front();
          offer   = 1'b1;
          next_x  = item.x;
          cur_gap = item.gap;
        end
      end
    end
    in_valid <= offer;
    x_value  <= next_x;
  end

  // Receiver stall: random short and long stalls, quiet windows, and one
  // long hold that backs the pipeline up into the input.
  always @(posedge clk_i) begin : stall_proc
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_cycle;
    int unsigned sel;
    logic        stall_now;
    stall_cycle++;
    stall_now = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      stall_now = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_now = 1'b1;
    end else if (stall_cycle[9:8] != 2'b00) begin
      sel = $urandom_range(0, 99);
      if (sel >= 92) begin
        stall_left = $urandom_range(9, 39);
        stall_now  = 1'b1;
      end else if (sel >= 65) begin
        stall_left = $urandom_range(0, 2);
        stall_now  = 1'b1;
      end
    end
    out_stall <= rst_ni && stall_now;
  end

  // Result checker: each accepted word against the oldest prediction.
  always @(posedge clk_i) begin : check_proc
    logic [e2hp_pkg::OUT_W-1:0] want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (pending_powers.size() == 0) begin
        report_mismatch("unexpected power_value", '0, power_value);
      end else begin
        want = pending_powers.pop_front();
        if (power_value !== want) begin
          report_mismatch("power_value", want, power_value);
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk_i) begin : watchdog_proc
    int unsigned quiet_cycles;
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_powers.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus_proc
    logic signed [e2hp_pkg::X_W-1:0] directed [$];
    exponent_item_t                  item;
    int unsigned                     sel;
    int                              i;

    // Zero, the ends of [-1, 1], values next to them, the smallest steps,
    // half points, alternating bits, and words outside [-1, 1], whose positive ones
    // reach the saturation of the result.
    directed = '{
      64'sh0000000000000000, 64'sh4000000000000000, 64'shc000000000000000,
      64'sh3fffffffffffffff, 64'shc000000000000001, 64'sh0000000000000001,
      64'shffffffffffffffff, 64'sh2000000000000000, 64'she000000000000000,
      64'sh5555555555555555, 64'shaaaaaaaaaaaaaaaa, 64'sh8000000000000000,
      64'sh7fffffffffffffff, 64'sh6000000000000000, 64'sha000000000000000,
      64'sh4000000000000001, 64'sh1000000000000000, 64'shf000000000000000
    };
    foreach (directed[j]) begin
      item.x     = directed[j];
      item.gap   = 0;
      item.drain = 1'b0;
      exponent_queue.push_back(item);
    end

    for (i = 0; i < int'(RANDOM_ITEMS); i++) begin
      item.x     = random_exponent();
      item.drain = (i % 100 == 0);
      sel        = $urandom_range(0, 99);
      if (i >= 200 && i < 260) begin
        item.gap = 0;
      end else if (sel < 60) begin
        item.gap = 0;
      end else if (sel < 90) begin
        item.gap = $urandom_range(1, 3);
      end else begin
        item.gap = $urandom_range(10, 40);
      end
      exponent_queue.push_back(item);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (exponent_queue.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    while (pending_powers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
